// ----- hw/rtl/cordic_sine_generator_macros.svh -----
// ----------------------------------------------------------------------------
// cordic_sine_generator_macros.svh
// Assertion macros for the CORDIC sine generator; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef CORDIC_SINE_GENERATOR_MACROS_SVH
`define CORDIC_SINE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CSG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cordic_sine_generator: assertion failed");

// next-cycle implication
`define CSG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cordic_sine_generator: assertion failed");

`else

`define CSG_ASSERT_IMP(label, clk, rst, ante, cons)
`define CSG_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/csg_pkg.sv -----
// ----------------------------------------------------------------------------
// csg_pkg
// Shared constants, angle table and types of the CORDIC sine generator.
// ----------------------------------------------------------------------------
package csg_pkg;

   localparam int unsigned ITERATIONS_DEFAULT = 6;
   localparam int unsigned ATAN_DEPTH         = 16;
   localparam int unsigned ATAN_IDX_W         = $clog2(ATAN_DEPTH);

   localparam int unsigned PHASE_W  = 32;
   localparam int unsigned FRAC_W   = 31;   // folded quarter-turn, up to 2^30
   localparam int unsigned XY_W     = 34;   // Q2.30 plus guard bits
   localparam int unsigned Z_W      = 33;   // signed residual angle
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned Q_FRAC   = 30;
   localparam int unsigned PROD_W   = XY_W + SAMPLE_W;
   localparam int unsigned MAG_W    = PROD_W - Q_FRAC;

   localparam int unsigned FIFO_DEPTH = 4;

   localparam logic [PHASE_W-1:0] STEP_RESET       = 32'd89478485;
   localparam logic [PHASE_W-1:0] CORDIC_K_Q30     = 32'd652032874;
   // round(pi/2 * 2^32) minus 2^32
   localparam logic [PHASE_W-1:0] HALF_PI_FRAC     = 32'd2451551556;
   localparam logic signed [SAMPLE_W-1:0] SCALE_OUT = 16'sd32767;

   // atan(2^-i) in Q2.30
   localparam logic [31:0] ATAN_Q30 [ATAN_DEPTH] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
      32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
      32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
      32'd262144,    32'd131072,    32'd65536,     32'd32768
   };

   typedef struct packed {
      logic [FRAC_W-1:0] frac;
      logic              neg;
   } csg_item_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   neg;
   } csg_rot_type;

   typedef struct packed {
      logic advance;
      logic pop;
   } csg_back_status_type;

endpackage

// ----- hw/rtl/csg_front.sv -----
// ----------------------------------------------------------------------------
// csg_front
// Phase accumulator and quadrant fold; hands folded angles to the queue.
// ----------------------------------------------------------------------------
module csg_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [csg_pkg::PHASE_W-1:0]        csr_wdata,
   input  logic                               req_valid,
   input  logic                               req_restart,
   input  logic                               fifo_full,
   output logic                               req_ready,
   output logic                               push,
   output csg_pkg::csg_item_type              push_item
);

   logic [csg_pkg::PHASE_W-1:0] step_ff, step_in;
   logic [csg_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [csg_pkg::PHASE_W-1:0] phase_cur;
   logic [csg_pkg::PHASE_W-1:0] folded;

   assign req_ready = !fifo_full;
   assign push      = req_valid && req_ready;
   assign phase_cur = req_restart ? '0 : phase_ff;

   always_comb begin
      step_in  = csr_we ? csr_wdata : step_ff;
      phase_in = push ? phase_cur + step_ff : phase_ff;
   end

   // fold into first quadrant, keep sine sign
   always_comb begin
      case (phase_cur[csg_pkg::PHASE_W-1 -: 2])
         2'd0:    folded = phase_cur;
         2'd1:    folded = 32'h8000_0000 - phase_cur;
         2'd2:    folded = phase_cur - 32'h8000_0000;
         default: folded = '0 - phase_cur;
      endcase
      push_item.frac = folded[csg_pkg::FRAC_W-1:0];
      push_item.neg  = phase_cur[csg_pkg::PHASE_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= csg_pkg::STEP_RESET;
         phase_ff <= '0;
      end else begin
         step_ff  <= step_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- hw/rtl/csg_fifo.sv -----
// ----------------------------------------------------------------------------
// csg_fifo
// Short queue of folded angles between front and back.
// ----------------------------------------------------------------------------
module csg_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  csg_pkg::csg_item_type push_item,
   input  logic                  pop,
   output logic                  empty,
   output logic                  full,
   output csg_pkg::csg_item_type pop_item
);

   localparam int unsigned PTR_W = $clog2(csg_pkg::FIFO_DEPTH);

   csg_pkg::csg_item_type entries_ff [csg_pkg::FIFO_DEPTH];
   logic [PTR_W:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W:0] rd_ptr_ff, rd_ptr_in;

   assign empty    = (wr_ptr_ff == rd_ptr_ff);
   assign full     = (wr_ptr_ff[PTR_W] != rd_ptr_ff[PTR_W]) &&
                     (wr_ptr_ff[PTR_W-1:0] == rd_ptr_ff[PTR_W-1:0]);
   assign pop_item = entries_ff[rd_ptr_ff[PTR_W-1:0]];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff[PTR_W-1:0]] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/csg_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// csg_cordic_stage
// One registered rotation-mode CORDIC micro-rotation.
// ----------------------------------------------------------------------------
module csg_cordic_stage #(
   parameter int unsigned SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  csg_pkg::csg_rot_type in_rot,
   output logic                 out_valid,
   output csg_pkg::csg_rot_type out_rot
);

   logic                        valid_ff, valid_in;
   csg_pkg::csg_rot_type        rot_ff, rot_in;
   logic signed [csg_pkg::XY_W-1:0] dx, dy;
   logic signed [csg_pkg::Z_W-1:0]  angle;

   always_comb begin
      dx    = $signed(in_rot.x) >>> SHIFT;   // floor shift
      dy    = $signed(in_rot.y) >>> SHIFT;
      angle = $signed({1'b0, csg_pkg::ATAN_Q30[SHIFT[csg_pkg::ATAN_IDX_W-1:0]]});
      rot_in.neg = in_rot.neg;
      if (!in_rot.z[csg_pkg::Z_W-1]) begin
         rot_in.x = $signed(in_rot.x) - dy;
         rot_in.y = $signed(in_rot.y) + dx;
         rot_in.z = $signed(in_rot.z) - angle;
      end else begin
         rot_in.x = $signed(in_rot.x) + dy;
         rot_in.y = $signed(in_rot.y) - dx;
         rot_in.z = $signed(in_rot.z) + angle;
      end
      valid_in = enable ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rot_ff <= rot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;

endmodule

// ----- hw/rtl/csg_back.sv -----
// ----------------------------------------------------------------------------
// csg_back
// Angle conversion, CORDIC pipeline, output scaling and result register.
// ----------------------------------------------------------------------------
module csg_back #(
   parameter int unsigned ITERATIONS = csg_pkg::ITERATIONS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fifo_empty,
   input  csg_pkg::csg_item_type              fifo_item,
   input  logic                               out_ready,
   output csg_pkg::csg_back_status_type       status,
   output logic                               out_valid,
   output logic [csg_pkg::SAMPLE_W-1:0]       out_sample
);

   localparam int unsigned MUL_W = csg_pkg::FRAC_W + csg_pkg::PHASE_W;

   logic advance;
   logic pop;

   // angle multiply stage
   logic                        a_valid_ff, a_valid_in;
   logic [csg_pkg::FRAC_W-1:0]  a_frac_ff;
   logic [csg_pkg::FRAC_W-1:0]  a_prod_ff;
   logic                        a_neg_ff;
   logic [MUL_W-1:0]            mul_full;

   // angle sum stage and CORDIC chain
   logic                        z_valid_ff, z_valid_in;
   csg_pkg::csg_rot_type        z_rot_ff, z_rot_in;
   logic [csg_pkg::PHASE_W-1:0] z_sum;
   logic                        chain_valid [ITERATIONS+1];
   csg_pkg::csg_rot_type        chain_rot   [ITERATIONS+1];

   // scale stage
   logic                               m_valid_ff, m_valid_in;
   logic signed [csg_pkg::PROD_W-1:0]  m_prod_ff, m_prod_in;
   logic                               m_neg_ff;

   // output stage
   logic                               o_valid_ff, o_valid_in;
   logic [csg_pkg::SAMPLE_W-1:0]       o_sample_ff, o_sample_in;
   logic                               p_neg;
   logic [csg_pkg::PROD_W-1:0]         p_abs;
   logic [csg_pkg::MAG_W-1:0]          q;
   logic [csg_pkg::SAMPLE_W-1:0]       q_sat;

   assign advance        = !o_valid_ff || out_ready;
   assign pop            = advance && !fifo_empty;
   assign status.advance = advance;
   assign status.pop     = pop;

   assign mul_full = MUL_W'(fifo_item.frac) * MUL_W'(csg_pkg::HALF_PI_FRAC);

   always_comb begin
      a_valid_in = advance ? pop : a_valid_ff;

      // frac * round(pi/2 * 2^32) >> 32 = frac + (frac * HALF_PI_FRAC) >> 32
      z_sum          = csg_pkg::PHASE_W'(a_frac_ff) + csg_pkg::PHASE_W'(a_prod_ff);
      z_rot_in.x     = csg_pkg::XY_W'(csg_pkg::CORDIC_K_Q30);
      z_rot_in.y     = '0;
      z_rot_in.z     = {1'b0, z_sum};
      z_rot_in.neg   = a_neg_ff;
      z_valid_in     = advance ? a_valid_ff : z_valid_ff;

      m_prod_in  = $signed(chain_rot[ITERATIONS].y) * csg_pkg::SCALE_OUT;
      m_valid_in = advance ? chain_valid[ITERATIONS] : m_valid_ff;

      // truncate toward zero, apply sign, saturate to +-32767
      p_neg = m_prod_ff[csg_pkg::PROD_W-1];
      p_abs = p_neg ? -m_prod_ff : m_prod_ff;
      q     = p_abs[csg_pkg::PROD_W-1:csg_pkg::Q_FRAC];
      q_sat = (q > csg_pkg::MAG_W'(csg_pkg::SCALE_OUT)) ?
              csg_pkg::SCALE_OUT : q[csg_pkg::SAMPLE_W-1:0];
      o_sample_in = (p_neg ^ m_neg_ff) ? -q_sat : q_sat;
      o_valid_in  = advance ? m_valid_ff : o_valid_ff;
   end

   assign chain_valid[0] = z_valid_ff;
   assign chain_rot[0]   = z_rot_ff;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
      csg_cordic_stage #(
         .SHIFT (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (chain_valid[i]),
         .in_rot    (chain_rot[i]),
         .out_valid (chain_valid[i+1]),
         .out_rot   (chain_rot[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         z_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         z_valid_ff <= z_valid_in;
         m_valid_ff <= m_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_frac_ff   <= fifo_item.frac;
         a_neg_ff    <= fifo_item.neg;
         a_prod_ff   <= mul_full[MUL_W-1:csg_pkg::PHASE_W];
         z_rot_ff    <= z_rot_in;
         m_prod_ff   <= m_prod_in;
         m_neg_ff    <= chain_rot[ITERATIONS].neg;
         o_sample_ff <= o_sample_in;
      end
   end

   assign out_valid  = o_valid_ff;
   assign out_sample = o_sample_ff;

endmodule

// ----- hw/rtl/cordic_sine_generator.sv -----
// ----------------------------------------------------------------------------
// cordic_sine_generator - phase-accumulator sine oscillator, CORDIC pipeline
// Requests pass the queue, angle multiply, angle sum, rotations, scale, result.
// Throughput: one sample per cycle, fully pipelined, while rsp_tready keeps up.
// Reset (sync, active high): phase 0, step register 89478485, queue/pipe empty.
// ----------------------------------------------------------------------------
`include "cordic_sine_generator_macros.svh"

module cordic_sine_generator #(
   parameter int unsigned ITERATIONS = csg_pkg::ITERATIONS_DEFAULT  // 1 to 16
) (
   input  logic        clock,
   input  logic        reset,

   // configuration: phase increment per sample, fraction of a turn times 2^32
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,

   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] restart_phase, [7:1] zero

   // sample channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] sample, signed
);

   // Front: every request transfer reads the phase (or zero on restart),
   // folds it to the first quadrant with a sine sign, and advances the
   // accumulator by the step register. It only waits when the queue is full.
   // Back: pops the queue whenever its pipeline moves and it is not empty.
   // The whole pipeline holds while a finished sample sits unaccepted in the
   // result register; the queue keeps the front taking requests meanwhile.

   logic                        push;
   logic                        fifo_empty;
   logic                        fifo_full;
   csg_pkg::csg_item_type       push_item;
   csg_pkg::csg_item_type       pop_item;
   csg_pkg::csg_back_status_type back_status;

   csg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_tvalid),
      .req_restart (req_tdata[0]),
      .fifo_full   (fifo_full),
      .req_ready   (req_tready),
      .push        (push),
      .push_item   (push_item)
   );

   csg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (back_status.pop),
      .empty     (fifo_empty),
      .full      (fifo_full),
      .pop_item  (pop_item)
   );

   // angle multiply, angle sum, ITERATIONS rotations, scale, saturate, result register
   csg_back #(
      .ITERATIONS (ITERATIONS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .fifo_item  (pop_item),
      .out_ready  (rsp_tready),
      .status     (back_status),
      .out_valid  (rsp_tvalid),
      .out_sample (rsp_tdata)
   );

   // saturation is symmetric: -32768 never leaves the block
   `CSG_ASSERT_IMP(a_no_min_sample, clock, reset, rsp_tvalid, rsp_tdata != 16'h8000)

   // a full queue implies that the back's pop was low at the last clock edge
   `CSG_ASSERT_IMP(a_full_needs_stall, clock, reset, fifo_full, !$past(back_status.pop))

   // a pop with no incoming request frees a slot
   `CSG_ASSERT_NXT(a_pop_frees_slot, clock, reset, back_status.pop && !req_tvalid, !fifo_full)

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - cordic_sine_generator
// Drives sample requests with random restarts and gaps, reprograms the phase
// step between bursts, and checks every sample against a Q2.30 CORDIC model.
// ----------------------------------------------------------------------------

// Expected-sample tracker: keeps its own phase accumulator and step register
// and queues the sample each request transfer should produce.
class sine_scoreboard;

   localparam int unsigned STAGES = 6;
   localparam longint GAIN_Q30 = 64'sd652032874;           // 0.607252935
   localparam longint unsigned QUARTER_Q32 = 64'd6746518852;  // pi/2 * 2^32
   localparam longint FULL_SCALE = 64'sd32767;
   localparam logic [31:0] STEP_AT_RESET = 32'd89478485;

   longint arctan_q30 [16] = '{
      843314857, 497837829, 263043837, 133525159,
      67021687,  33543516,  16775851,  8388437,
      4194283,   2097149,   1048576,   524288,
      262144,    131072,    65536,     32768
   };

   logic [31:0]        phase;
   logic [31:0]        step;
   logic signed [15:0] expected_samples [$];
   int                 errors;

   function new();
      phase  = '0;
      step   = STEP_AT_RESET;
      errors = 0;
   endfunction

   function void write_step(logic [31:0] value);
      step = value;
   endfunction

   function int pending();
      return expected_samples.size();
   endfunction

   // sine of a phase given as a fraction of a turn, scaled to +-32767
   function logic signed [15:0] sine_of(logic [31:0] ph);
      longint unsigned folded;
      longint          x, y, z, dx, dy, prod, mag;
      logic            lower_half;
      lower_half = ph[31];
      case (ph[31:30])
         2'd0: folded = {32'b0, ph};
         2'd1: folded = 64'h8000_0000 - {32'b0, ph};
         2'd2: folded = {32'b0, ph} - 64'h8000_0000;
         default: folded = 64'h1_0000_0000 - {32'b0, ph};
      endcase
      z = longint'((folded * QUARTER_Q32) >> 32);
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (z >= 0) begin
            x = x - dy;
            y = y + dx;
            z = z - arctan_q30[i];
         end else begin
            x = x + dy;
            y = y - dx;
            z = z + arctan_q30[i];
         end
      end
      prod = y * FULL_SCALE;
      // truncate toward zero
      if (prod >= 0) begin
         mag = prod >>> 30;
      end else begin
         mag = -((-prod) >>> 30);
      end
      if (lower_half) begin
         mag = -mag;
      end
      if (mag > FULL_SCALE) begin
         mag = FULL_SCALE;
      end
      if (mag < -FULL_SCALE) begin
         mag = -FULL_SCALE;
      end
      return mag[15:0];
   endfunction

   function void note_request(logic restart);
      if (restart) begin
         phase = '0;
      end
      expected_samples.push_back(sine_of(phase));
      phase = phase + step;
   endfunction

   function void check_sample(logic [15:0] got);
      logic signed [15:0] want;
      if (expected_samples.size() == 0) begin
         $display("%0t: unexpected sample %0d", $time, $signed(got));
         errors++;
      end else begin
         want = expected_samples.pop_front();
         if (want !== $signed(got)) begin
            $display("%0t: sample mismatch, expected %0d, got %0d",
                     $time, want, $signed(got));
            errors++;
         end
      end
   endfunction

endclass

module testbench;

   localparam int unsigned ITERATIONS  = 6;
   localparam int unsigned LATENCY     = ITERATIONS + 4;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned BURSTS      = 6;
   localparam int unsigned BURST_LEN   = 170;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [0] restart_phase, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] sample, signed

   sine_scoreboard board = new();

   // idle odds, percent of cycles
   int unsigned send_idle_pct = 37;
   int unsigned recv_idle_pct = 71;
   int unsigned quiet_cycles  = 0;

   cordic_sine_generator #(.ITERATIONS(ITERATIONS)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Sample side: check each transfer, then pick the next cycle's tready.
   // Both use the values sampled at the edge, before any update lands.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_sample(rsp_tdata);
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: too long without any transfer on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // One request transfer; tvalid stays high afterwards so back-to-back
   // requests need no second assignment in the same step.
   task automatic send(input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, restart};
      do @(posedge clock); while (!req_tready);
      board.note_request(restart);
   endtask

   // Hold off requests until every sample is back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Phase step is only changed with the pipe empty.
   task automatic program_step(input logic [31:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_step(value);
   endtask

   initial begin
      logic [31:0] step_value;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // reset step: phase starts at zero, restart mid-run
      send(1'b0);
      send(1'b0);
      send(1'b1);
      send(1'b0);
      // quarter-turn step walks every quadrant boundary and wraps to zero
      program_step(32'h4000_0000);
      send(1'b1);
      repeat (5) send(1'b0);
      // half-turn step: exact half turn folds to a zero angle with negative sign
      program_step(32'h8000_0000);
      send(1'b1);
      send(1'b0);
      send(1'b0);
      // all-ones step wraps to just below a full turn
      program_step(32'hFFFF_FFFF);
      send(1'b1);
      send(1'b0);
      send(1'b0);
      // zero step holds the phase
      program_step(32'h0000_0000);
      send(1'b0);
      send(1'b1);
      send(1'b0);

      // --- random bursts, each with its own step ---
      for (int b = 0; b < BURSTS; b++) begin
         case (b)
            0: step_value = $urandom;
            1: step_value = $urandom_range(32'h00FF_FFFF, 1);
            2: step_value = 32'h8000_0000 - $urandom_range(255, 0);
            3: step_value = $urandom_range(32'h7FFF_FFFF, 0);
            4: step_value = 32'hFFFF_FFFF - $urandom_range(32'h0001_0000, 0);
            default: step_value = 32'd89478485;
         endcase
         program_step(step_value);
         // idle pattern: sender 37 / receiver 71, then swapped, then none
         case (b / 2)
            0: begin
               send_idle_pct = 37;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 37;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < BURST_LEN; n++) begin
            // sender pause mid-burst until the pipe runs dry
            if (b == 2 && n == BURST_LEN / 2) begin
               drain();
            end
            send($urandom_range(19) == 0);
         end
      end

      drain();
      repeat (LATENCY + 2) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// ----- cordic_sine_generator.f -----
+incdir+hw/rtl
hw/rtl/csg_pkg.sv
hw/rtl/csg_front.sv
hw/rtl/csg_fifo.sv
hw/rtl/csg_cordic_stage.sv
hw/rtl/csg_back.sv
hw/rtl/cordic_sine_generator.sv
test/testbench.sv
